// ===== rtl/ttgw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttgw_pkg: shared types and constants for the text terminal grid writer
// Grid geometry, character codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ttgw_pkg;

  localparam int GRID_COLS  = 74;
  localparam int GRID_ROWS  = 28;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam int TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'd27;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_FINLO = 8'h40;
  localparam logic [CHAR_W-1:0] CH_FINHI = 8'h7E;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } ttgw_state_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } ttgw_esc_t;

  // logical cell position, before the row rotation
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } ttgw_cell_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [CHAR_W-1:0] wdata;
  } ttgw_mem_t;

endpackage

`default_nettype wire

// ===== rtl/ttgw_if.sv =====
// ----------------------------------------------------------------------------
// ttgw_if: request and response channels of the terminal grid writer
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttgw_req_if import ttgw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [7:0]       byte_value;
  logic [ROW_W-1:0] read_row;
  logic [COL_W-1:0] read_col;

  modport source (output valid, kind, byte_value, read_row, read_col, input ready);
  modport sink   (input valid, kind, byte_value, read_row, read_col, output ready);
endinterface

interface ttgw_rsp_if import ttgw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  modport source (output valid, cell_char, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_char, cursor_col, cursor_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/text_terminal_grid_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_terminal_grid_writer_core: character-cell terminal over a 74x28 grid
// Byte processing with CSI swallowing, cell readback and scrolling.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole grid to spaces, one cell per cycle,
// with req.ready low. It then takes one item at a time: a byte item passes
// through the EXEC and DONE states, a cell read through EXEC, READ and DONE
// (the grid RAM has a registered read), and the result enters the output
// register from DONE once that register is free or being drained.
// A line feed or wrap on the bottom row scrolls by rotating a top-row
// pointer, then blanks the new bottom row through the single RAM port
// in the SCROLL state. req.ready rises again in the cycle after a result enters
// the output register, even if it is still waiting to be taken.
`default_nettype none

module text_terminal_grid_writer_core import ttgw_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  ttgw_req_if.sink   req,
  ttgw_rsp_if.source rsp
);

  ttgw_cell_t        cell_req;
  logic [ROW_W-1:0]  top_row;
  ttgw_mem_t         mem;
  logic [ADDR_W-1:0] addr;
  logic [CHAR_W-1:0] rdata;

  ttgw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cell_req (cell_req),
    .top_row  (top_row),
    .mem      (mem),
    .rdata    (rdata)
  );

  ttgw_addr u_addr (
    .pos     (cell_req),
    .top_row (top_row),
    .addr    (addr)
  );

  ttgw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (mem.we),
    .re    (mem.re),
    .addr  (addr),
    .wdata (mem.wdata),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/ttgw_ram.sv =====
// ----------------------------------------------------------------------------
// ttgw_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttgw_addr.sv =====
// ----------------------------------------------------------------------------
// ttgw_addr: shared cell address unit
// Rotates the logical row by the top-row pointer and flattens row/col.
// ----------------------------------------------------------------------------
`default_nettype none

module ttgw_addr import ttgw_pkg::*; (
  input  wire ttgw_cell_t       pos,
  input  wire logic [ROW_W-1:0] top_row,
  output      logic [ADDR_W-1:0] addr
);

  logic [ROW_W:0]   sum;
  logic [ROW_W-1:0] phys;

  always_comb begin
    sum = {1'b0, pos.row} + {1'b0, top_row};
    if (sum >= (ROW_W+1)'(GRID_ROWS)) begin
      phys = ROW_W'(sum - (ROW_W+1)'(GRID_ROWS));
    end else begin
      phys = sum[ROW_W-1:0];
    end
    addr = ADDR_W'(phys) * ADDR_W'(GRID_COLS) + ADDR_W'(pos.col);
  end

endmodule

`default_nettype wire

// ===== rtl/ttgw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttgw_ctrl: terminal sequencer
// Byte decode, cursor and escape state, row rotation, clear sweeps and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttgw_ctrl import ttgw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  ttgw_req_if.sink               req,
  ttgw_rsp_if.source             rsp,
  output      ttgw_cell_t        cell_req,
  output      logic [ROW_W-1:0]  top_row,
  output      ttgw_mem_t         mem,
  input  wire logic [CHAR_W-1:0] rdata
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

  ttgw_state_t state, state_next;
  ttgw_esc_t   esc_phase, esc_next;

  logic [COL_W-1:0] col_pos, col_next;
  logic [ROW_W-1:0] row_pos, row_next;
  logic [COL_W-1:0] clr_col;
  logic [ROW_W-1:0] clr_row;
  logic             out_valid;

  // captured item
  logic              kind_r;
  logic [CHAR_W-1:0] byte_r;
  logic [ROW_W-1:0]  rrow;
  logic [COL_W-1:0]  rcol;
  logic [CHAR_W-1:0] cell_r;

  logic [CHAR_W-1:0] out_char;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;

  logic             dec_wr;
  logic             dec_scroll;
  logic             adv;
  logic [COL_W:0]   tab_sum;
  logic             rd_ok;
  logic             accept;
  logic             load;

  assign accept = req.valid && req.ready;
  assign load   = (state == ST_DONE) && (!out_valid || rsp.ready);
  assign rd_ok  = (rrow < ROW_W'(GRID_ROWS)) && (rcol < COL_W'(GRID_COLS));

  assign rsp.valid      = out_valid;
  assign rsp.cell_char  = out_char;
  assign rsp.cursor_col = out_col;
  assign rsp.cursor_row = out_row;

  // byte decode
  always_comb begin
    col_next   = col_pos;
    row_next   = row_pos;
    esc_next   = esc_phase;
    dec_wr     = 1'b0;
    adv        = 1'b0;
    dec_scroll = 1'b0;
    tab_sum    = ({1'b0, col_pos} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
    case (esc_phase)
      ESC_NONE: begin
        case (byte_r)
          CH_ESC: esc_next = ESC_SEEN;
          CH_CR:  col_next = '0;
          CH_LF: begin
            col_next = '0;
            adv      = 1'b1;
          end
          CH_BS: begin
            if (col_pos != '0) begin
              col_next = col_pos - COL_W'(1);
            end
          end
          CH_TAB: begin
            if (tab_sum >= (COL_W+1)'(GRID_COLS)) begin
              col_next = LAST_COL;
            end else begin
              col_next = tab_sum[COL_W-1:0];
            end
          end
          default: begin
            if (byte_r >= CH_SPACE) begin
              dec_wr = 1'b1;
              if (col_pos == LAST_COL) begin
                col_next = '0;
                adv      = 1'b1;
              end else begin
                col_next = col_pos + COL_W'(1);
              end
            end
          end
        endcase
      end
      ESC_SEEN: esc_next = (byte_r == CH_LBRK) ? ESC_CSI : ESC_NONE;
      default: begin
        if (byte_r >= CH_FINLO && byte_r <= CH_FINHI) begin
          esc_next = ESC_NONE;
        end
      end
    endcase
    if (adv) begin
      if (row_pos == LAST_ROW) begin
        dec_scroll = 1'b1;
      end else begin
        row_next = row_pos + ROW_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_col == LAST_COL && clr_row == LAST_ROW) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (kind_r == KIND_READ) begin
          state_next = ST_READ;
        end else if (dec_scroll) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ:   state_next = ST_DONE;
      ST_SCROLL: begin
        if (clr_col == LAST_COL) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    cell_req  = '{row: clr_row, col: clr_col};
    mem       = '{we: 1'b0, re: 1'b0, wdata: CH_SPACE};
    case (state)
      ST_CLEAR: mem.we = 1'b1;
      ST_IDLE:  req.ready = 1'b1;
      ST_EXEC: begin
        if (kind_r == KIND_READ) begin
          cell_req = '{row: rrow, col: rcol};
          mem.re   = rd_ok;
        end else begin
          cell_req  = '{row: row_pos, col: col_pos};
          mem.we    = dec_wr;
          mem.wdata = byte_r;
        end
      end
      ST_SCROLL: begin
        cell_req = '{row: LAST_ROW, col: clr_col};
        mem.we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      col_pos   <= '0;
      row_pos   <= '0;
      esc_phase <= ESC_NONE;
      top_row   <= '0;
      clr_col   <= '0;
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && !rsp.ready) || load;
      case (state)
        ST_CLEAR: begin
          if (clr_col == LAST_COL) begin
            clr_col <= '0;
            clr_row <= clr_row + ROW_W'(1);
          end else begin
            clr_col <= clr_col + COL_W'(1);
          end
        end
        ST_EXEC: begin
          if (kind_r == KIND_BYTE) begin
            col_pos   <= col_next;
            row_pos   <= row_next;
            esc_phase <= esc_next;
            clr_col   <= '0;
            if (dec_scroll) begin
              // oldest row becomes the new bottom row
              top_row <= (top_row == LAST_ROW) ? '0 : top_row + ROW_W'(1);
            end
          end
        end
        ST_SCROLL: clr_col <= clr_col + COL_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= req.kind;
      byte_r <= req.byte_value;
      rrow   <= req.read_row;
      rcol   <= req.read_col;
    end
    if (state == ST_EXEC) begin
      cell_r <= '0;
    end else if (state == ST_READ) begin
      cell_r <= rd_ok ? rdata : '0;
    end
    if (load) begin
      out_char <= cell_r;
      out_col  <= col_pos;
      out_row  <= row_pos;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_pos < COL_W'(GRID_COLS))
    else $error("cursor column out of grid");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_pos < ROW_W'(GRID_ROWS) && top_row < ROW_W'(GRID_ROWS))
    else $error("cursor row or top row out of grid");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem.we && mem.re))
    else $error("RAM read and write in the same cycle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready && !load)
    else $error("item accepted while sequencer busy or result loaded too early");

endmodule

`default_nettype wire

// ===== tb/sv/text_terminal_grid_writer_core_tb.sv =====
// ----------------------------------------------------------------------------
// text_terminal_grid_writer_core_tb: self-checking bench for the terminal core
// Feeds terminal bytes and cell reads over the request channel. A shadow
// terminal predicts the cell and cursor report of every transaction, and each
// response is compared against it in order. Both sides stall at random, and
// the response side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module text_terminal_grid_writer_core_tb;
  import ttgw_pkg::*;

  localparam logic [CHAR_W-1:0] CH_BELL = 8'd7;
  localparam int LONG_HOLD = 250;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } cursor_report_t;

  logic clk;
  logic rst;

  ttgw_req_if req_ch ();
  ttgw_rsp_if rsp_ch ();

  text_terminal_grid_writer_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the terminal
  logic [CHAR_W-1:0] shadow_grid [GRID_ROWS][GRID_COLS];
  logic [COL_W-1:0]  shadow_col;
  logic [ROW_W-1:0]  shadow_row;
  ttgw_esc_t         shadow_esc;

  cursor_report_t expected_reports [$];

  int fail_count;
  int items_sent;
  int reads_sent;
  int results_seen;
  int scroll_count;
  int csi_count;
  bit idle_on;
  int rx_hold_len;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 600000);
    $display("Timed out with %0d results still pending", expected_reports.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void scroll_shadow();
    for (int r = 0; r < GRID_ROWS - 1; r++)
      for (int c = 0; c < GRID_COLS; c++)
        shadow_grid[r][c] = shadow_grid[r + 1][c];
    for (int c = 0; c < GRID_COLS; c++)
      shadow_grid[GRID_ROWS - 1][c] = CH_SPACE;
    scroll_count++;
  endfunction

  function automatic void next_line();
    if (shadow_row == ROW_W'(GRID_ROWS - 1)) scroll_shadow();
    else shadow_row++;
  endfunction

  function automatic void put_terminal_byte(logic [CHAR_W-1:0] b);
    int t;
    if (shadow_esc == ESC_SEEN) begin
      if (b == CH_LBRK) begin
        shadow_esc = ESC_CSI;
        csi_count++;
      end else begin
        shadow_esc = ESC_NONE;
      end
      return;
    end
    // CSI body: swallow until a final byte
    if (shadow_esc != ESC_NONE) begin
      if (b >= CH_FINLO && b <= CH_FINHI) shadow_esc = ESC_NONE;
      return;
    end
    case (b)
      CH_ESC: shadow_esc = ESC_SEEN;
      CH_CR: shadow_col = '0;
      CH_LF: begin
        shadow_col = '0;
        next_line();
      end
      CH_BS: if (shadow_col != 0) shadow_col--;
      CH_TAB: begin
        t = (int'(shadow_col) + TAB_STEP) & ~(TAB_STEP - 1);
        if (t >= GRID_COLS) t = GRID_COLS - 1;
        shadow_col = COL_W'(t);
      end
      default: if (b >= CH_SPACE) begin
        shadow_grid[shadow_row][shadow_col] = b;
        if (shadow_col == COL_W'(GRID_COLS - 1)) begin
          shadow_col = '0;
          next_line();
        end else begin
          shadow_col++;
        end
      end
    endcase
  endfunction

  function automatic cursor_report_t terminal_step(logic kind, logic [CHAR_W-1:0] b,
                                                   logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    cursor_report_t rep;
    rep.cell_char = '0;
    if (kind == KIND_BYTE) put_terminal_byte(b);
    else if (r < GRID_ROWS && c < GRID_COLS) rep.cell_char = shadow_grid[r][c];
    rep.cursor_col = shadow_col;
    rep.cursor_row = shadow_row;
    return rep;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(logic kind, logic [CHAR_W-1:0] b,
                           logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.byte_value <= b;
    req_ch.read_row   <= r;
    req_ch.read_col   <= c;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_reports.push_back(terminal_step(kind, b, r, c));
    items_sent++;
    if (kind == KIND_READ) reads_sent++;
  endtask

  // unused fields get random values so every bit toggles
  task automatic put_byte_item(logic [CHAR_W-1:0] b);
    send_item(KIND_BYTE, b, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_cell_item(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    send_item(KIND_READ, CHAR_W'($urandom), r, c);
  endtask

  // response side: random stalls, plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      if (rx_hold_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    cursor_report_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("arrived with nothing pending", 32'(rsp_ch.cursor_col), 0);
      end else begin
        want = expected_reports.pop_front();
        if (rsp_ch.cell_char !== want.cell_char)
          report_mismatch("cell_char", 32'(rsp_ch.cell_char), 32'(want.cell_char));
        if (rsp_ch.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", 32'(rsp_ch.cursor_col), 32'(want.cursor_col));
        if (rsp_ch.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", 32'(rsp_ch.cursor_row), 32'(want.cursor_row));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_cleared_grid();
    read_cell_item('0, '0);
    read_cell_item(ROW_W'(GRID_ROWS - 1), COL_W'(GRID_COLS - 1));
    read_cell_item('1, '1);
    read_cell_item('0, COL_W'(GRID_COLS));
  endtask

  task automatic test_control_bytes();
    put_byte_item("A");
    put_byte_item(8'hFF);
    put_byte_item(8'h7F);
    put_byte_item(CH_BS);
    put_byte_item(CH_CR);
    put_byte_item(CH_BS);     // already at column 0
    put_byte_item(CH_TAB);
    put_byte_item(CH_BELL);
    put_byte_item(CH_LF);
    read_cell_item('0, COL_W'(1));     // backspace must not have erased it
  endtask

  task automatic test_escape_sequences();
    put_byte_item(CH_ESC);
    put_byte_item("x");
    put_byte_item(CH_ESC);
    put_byte_item(CH_ESC);
    put_byte_item(CH_ESC);
    put_byte_item(CH_LBRK);
    put_byte_item("1");
    put_byte_item(CH_ESC);    // swallowed inside CSI
    put_byte_item(CH_FINHI);
    put_byte_item(CH_ESC);
    put_byte_item(CH_LBRK);
    put_byte_item(CH_FINLO);
    put_byte_item("Z");
    read_cell_item(ROW_W'(1), '0);
  endtask

  task automatic test_output_backpressure();
    rx_hold_len = LONG_HOLD;
    repeat (24) put_byte_item(CHAR_W'($urandom_range(8'h21, 8'h7E)));
  endtask

  task automatic random_sequence();
    int pick;
    int len;
    logic [CHAR_W-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // text line, sometimes long enough to wrap
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 12);
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) b = CHAR_W'($urandom_range(8'h7F, 8'hFF));
        else b = CHAR_W'($urandom_range(CH_SPACE, 8'h7E));
        put_byte_item(b);
      end
      case ($urandom_range(0, 3))
        0: put_byte_item(CH_LF);
        1: begin
          put_byte_item(CH_CR);
          put_byte_item(CH_LF);
        end
        default: ;
      endcase
    end else if (pick < 60) begin
      if ($urandom_range(0, 4) == 0) read_cell_item(ROW_W'($urandom), COL_W'($urandom));
      else read_cell_item(ROW_W'($urandom_range(0, GRID_ROWS - 1)),
                          COL_W'($urandom_range(0, GRID_COLS - 1)));
    end else if (pick < 70) begin
      put_byte_item(CH_ESC);
      put_byte_item(CH_LBRK);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 9) == 0) b = CHAR_W'($urandom_range(0, 31));
        else b = CHAR_W'($urandom_range(CH_SPACE, CH_FINLO - 1));
        put_byte_item(b);
      end
      put_byte_item(CHAR_W'($urandom_range(CH_FINLO, CH_FINHI)));
    end else if (pick < 75) begin
      put_byte_item(CH_ESC);
      put_byte_item(CHAR_W'($urandom));
    end else if (pick < 83) begin
      case ($urandom_range(0, 4))
        0: put_byte_item(CH_BS);
        1: put_byte_item(CH_TAB);
        2: put_byte_item(CH_CR);
        3: put_byte_item(CH_LF);
        default: put_byte_item(CHAR_W'($urandom_range(0, 31)));
      endcase
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 12)) put_byte_item(CH_TAB);
    end else if (pick < 94) begin
      put_byte_item(CHAR_W'($urandom));
    end else begin
      // CSI left open; later text closes it
      put_byte_item(CH_ESC);
      put_byte_item(CH_LBRK);
      repeat ($urandom_range(1, 4)) put_byte_item(CHAR_W'($urandom_range(0, 8'h3F)));
    end
  endtask

  task automatic test_random_traffic(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_sequence();
  endtask

  task automatic test_back_to_back(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_sequence();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++)
        shadow_grid[r][c] = CH_SPACE;
    shadow_col   = '0;
    shadow_row   = '0;
    shadow_esc   = ESC_NONE;
    fail_count   = 0;
    items_sent   = 0;
    reads_sent   = 0;
    results_seen = 0;
    scroll_count = 0;
    csi_count    = 0;
    idle_on      = 1'b0;
    rx_hold_len  = 0;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= KIND_BYTE;
    req_ch.byte_value <= '0;
    req_ch.read_row   <= '0;
    req_ch.read_col   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_cleared_grid();
    test_control_bytes();
    test_escape_sequences();
    idle_on = 1'b1;
    test_output_backpressure();
    test_random_traffic(1250);
    idle_on = 1'b0;
    test_back_to_back(350);
    req_ch.valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d transactions (%0d cell reads); model saw %0d scrolls and %0d CSI runs",
             items_sent, reads_sent, scroll_count, csi_count);
    $display("Included control bytes, lone escapes, tab clamping, wraps and a %0d-cycle stall",
             LONG_HOLD);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ttgw_pkg.sv
rtl/ttgw_if.sv
rtl/ttgw_ram.sv
rtl/ttgw_addr.sv
rtl/ttgw_ctrl.sv
rtl/text_terminal_grid_writer_core.sv
tb/sv/text_terminal_grid_writer_core_tb.sv
